>>> sv/record_insertion_sorter_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the record sorter.
// ---------------------------------------------------------------------------
`ifndef RECORD_INSERTION_SORTER_CORE_ASSERT_SVH
`define RECORD_INSERTION_SORTER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RIS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define RIS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/ris_pkg.sv
// ---------------------------------------------------------------------------
// Record sorter package
// Widths, store entry type, controller states and command/status groups.
// ---------------------------------------------------------------------------
package ris_pkg;

    localparam int MAX_RECORDS = 16;
    localparam int KEY_W       = 27;
    localparam int NAME_W      = 32;
    localparam int SCORE_W     = 64;
    localparam int ADDR_W      = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [NAME_W-1:0]  name;
        logic [SCORE_W-1:0] score;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLACE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic drop;
        logic rd_ins;
        logic wr_shift;
        logic wr_new;
        logic rd_emit;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic full;
        logic last;
        logic pos_zero;
        logic key_less;
        logic emit_final;
        logic out_free;
    } t_stat;

endpackage

>>> sv/ris_rec_if.sv
// ---------------------------------------------------------------------------
// Record channel
// Valid/ready channel carrying one input record per item.
// ---------------------------------------------------------------------------
interface ris_rec_if;
    import ris_pkg::*;

    logic               valid;
    logic               ready;
    logic [KEY_W-1:0]   record_key;
    logic [NAME_W-1:0]  record_name;
    logic [SCORE_W-1:0] record_score;
    logic               record_last;

    modport source (
        output valid, record_key, record_name, record_score, record_last,
        input  ready
    );

    modport sink (
        input  valid, record_key, record_name, record_score, record_last,
        output ready
    );
endinterface

>>> sv/ris_sort_if.sv
// ---------------------------------------------------------------------------
// Sorted channel
// Valid/ready channel carrying one sorted record per item.
// ---------------------------------------------------------------------------
interface ris_sort_if;
    import ris_pkg::*;

    logic               valid;
    logic               ready;
    logic [KEY_W-1:0]   sorted_key;
    logic [NAME_W-1:0]  sorted_name;
    logic [SCORE_W-1:0] sorted_score;
    logic               sorted_last;
    logic               overflowed;

    modport source (
        output valid, sorted_key, sorted_name, sorted_score, sorted_last, overflowed,
        input  ready
    );

    modport sink (
        input  valid, sorted_key, sorted_name, sorted_score, sorted_last, overflowed,
        output ready
    );
endinterface

>>> sv/ris_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module ris_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/ris_ctrl.sv
// ---------------------------------------------------------------------------
// Record sorter controller
// Sequences acceptance, insertion walk and emission of the sorted set.
// ---------------------------------------------------------------------------
module ris_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ris_pkg::t_stat i_stat,
    output ris_pkg::t_cmd  o_cmd
);
    import ris_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_stat.in_valid) begin
                    n_state = ST_PLACE;
                end
            end
            ST_PLACE: begin
                if (i_stat.full) begin
                    n_state = i_stat.last ? ST_EMIT_RD : ST_IDLE;
                end else begin
                    n_state = ST_INS_RD;
                end
            end
            ST_INS_RD: begin
                if (i_stat.pos_zero) begin
                    n_state = i_stat.last ? ST_EMIT_RD : ST_IDLE;
                end else begin
                    n_state = ST_INS_CMP;
                end
            end
            ST_INS_CMP: begin
                if (i_stat.key_less) begin
                    n_state = ST_INS_RD;
                end else begin
                    n_state = i_stat.last ? ST_EMIT_RD : ST_IDLE;
                end
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.emit_final ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = i_rst_n;
            end
            ST_PLACE: begin
                o_cmd.drop = i_stat.full;
            end
            ST_INS_RD: begin
                o_cmd.wr_new = i_stat.pos_zero;
                o_cmd.rd_ins = !i_stat.pos_zero;
            end
            ST_INS_CMP: begin
                o_cmd.wr_shift = i_stat.key_less;
                o_cmd.wr_new   = !i_stat.key_less;
            end
            ST_EMIT_RD: begin
                o_cmd.rd_emit = 1'b1;
            end
            ST_EMIT_LD: begin
                o_cmd.load_out = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end
endmodule

>>> sv/ris_dp.sv
// ---------------------------------------------------------------------------
// Record sorter datapath
// Record holding, store RAM, insertion position, fill count and output register.
// ---------------------------------------------------------------------------
module ris_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ris_pkg::t_cmd  i_cmd,
    output ris_pkg::t_stat o_stat,
    ris_rec_if.sink        i_rec,
    ris_sort_if.source     o_sort
);
    import ris_pkg::*;

    t_entry             r_rec;
    logic               r_last;
    logic [ADDR_W-1:0]  r_pos;
    logic [CNT_W-1:0]   r_fill;
    logic               r_ovf;
    logic [ADDR_W-1:0]  r_emit_idx;
    logic               r_out_valid;
    t_entry             r_out;
    logic               r_out_last;
    logic               r_out_ovf;

    logic               accept;
    logic               emit_final;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    t_entry             mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;
    t_entry             mem_rdata;

    assign accept     = i_rec.valid & i_cmd.in_ready;
    assign emit_final = (CNT_W'(r_emit_idx) + CNT_W'(1)) == r_fill;

    assign mem_we    = i_cmd.wr_shift | i_cmd.wr_new;
    assign mem_waddr = r_pos;
    assign mem_wdata = i_cmd.wr_shift ? mem_rdata : r_rec;
    assign mem_re    = i_cmd.rd_ins | i_cmd.rd_emit;
    assign mem_raddr = i_cmd.rd_emit ? r_emit_idx : (r_pos - ADDR_W'(1));

    ris_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_RECORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rec.key   <= i_rec.record_key;
            r_rec.name  <= i_rec.record_name;
            r_rec.score <= i_rec.record_score;
            r_last      <= i_rec.record_last;
        end
        if (i_cmd.load_out) begin
            r_out      <= mem_rdata;
            r_out_last <= emit_final;
            r_out_ovf  <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_fill      <= '0;
            r_ovf       <= 1'b0;
            r_emit_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_pos <= ADDR_W'(r_fill);
            end else if (i_cmd.wr_shift) begin
                r_pos <= r_pos - ADDR_W'(1);
            end
            if (i_cmd.drop) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.wr_new) begin
                r_fill <= r_fill + CNT_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
                if (emit_final) begin
                    r_fill     <= '0;
                    r_ovf      <= 1'b0;
                    r_emit_idx <= '0;
                end else begin
                    r_emit_idx <= r_emit_idx + ADDR_W'(1);
                end
            end else if (o_sort.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.in_valid   = i_rec.valid;
    assign o_stat.full       = r_fill == CNT_W'(MAX_RECORDS);
    assign o_stat.last       = r_last;
    assign o_stat.pos_zero   = r_pos == '0;
    assign o_stat.key_less   = r_rec.key < mem_rdata.key;
    assign o_stat.emit_final = emit_final;
    assign o_stat.out_free   = !r_out_valid | o_sort.ready;

    assign o_sort.valid        = r_out_valid;
    assign o_sort.sorted_key   = r_out.key;
    assign o_sort.sorted_name  = r_out.name;
    assign o_sort.sorted_score = r_out.score;
    assign o_sort.sorted_last  = r_out_last;
    assign o_sort.overflowed   = r_out_ovf;

`include "record_insertion_sorter_core_assert.svh"

    `RIS_ASSERT_NOW(a_fill_bound, 1'b1, r_fill <= CNT_W'(MAX_RECORDS), "fill count past capacity")
    `RIS_ASSERT_NOW(a_write_excl, mem_we, !(i_cmd.wr_shift && i_cmd.wr_new), "two store writes")
    `RIS_ASSERT_NOW(a_no_write_full, i_cmd.wr_new, !o_stat.full, "insert into full store")
    `RIS_ASSERT_NEXT(a_set_clear, i_cmd.load_out && emit_final, r_fill == '0 && !r_ovf,
        "set state not cleared after final item")
endmodule

>>> sv/record_insertion_sorter_core.sv
// ---------------------------------------------------------------------------
// Record insertion sorter
// Sorts a set of records by ascending key and emits it on the last record.
// ---------------------------------------------------------------------------
// Input channel i_rec takes one record per item: key, name, score, last flag.
// Each record is placed into a store of MAX_RECORDS entries kept in key order;
// equal keys stay in arrival order. A record arriving at a full store is
// dropped and the set is marked as overflowed.
// An accepted record is fully placed before the next item is taken. At a full
// store it is dropped at once; else the insertion walk moves the entries with a
// greater key up one place each, one at a time over the single read port, and
// then writes the record into the freed slot.
// On a record flagged last the set is emitted on o_sort, one item per stored
// record; each item is read from the store, then loaded into the output register
// once that register is free; sorted_last marks the final
// item and overflowed is the same on every item of the set.
// The output register holds an item until it is taken; a stalled receiver
// halts emission, and a new record is taken while the final item still waits.
// Reset empties the set and clears the overflow mark; no input is taken
// during reset or emission.
// ---------------------------------------------------------------------------
module record_insertion_sorter_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ris_rec_if.sink    i_rec,
    ris_sort_if.source o_sort
);
    import ris_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign i_rec.ready = cmd.in_ready;

    ris_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    ris_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_rec   (i_rec),
        .o_sort  (o_sort)
    );
endmodule
